/* sv/rolling_average_crc_frame_builder_defines.svh */
// Assertion macros for the rolling average CRC frame builder.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef ROLLING_AVERAGE_CRC_FRAME_BUILDER_DEFINES_SVH
`define ROLLING_AVERAGE_CRC_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RACFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("racfb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RACFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("racfb assertion failed");

`endif

/* sv/racfb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and functions of the rolling average CRC frame builder.
// No dependencies; used by the interfaces and the top level.
package racfb_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int PRES_W        = 24;
  localparam int TEMP_W        = 16;
  localparam int PSUM_W        = PRES_W + ADDR_W;
  localparam int TSUM_W        = TEMP_W + ADDR_W;
  localparam int DIV_CNT_W     = $clog2(PSUM_W);
  localparam int HIST_W        = PRES_W + TEMP_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_EN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SEL = 1'b1;

  // Window select codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  PAD_BYTE = 8'h00;

  localparam logic [2:0] CRC_LAST_IDX  = 3'd5;
  localparam logic [2:0] FRAME_LAST_IDX = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_P,
    ST_DIV_T,
    ST_CRC,
    ST_OUT
  } racfb_state_t;

  function automatic logic [CNT_W-1:0] window_size(input logic [1:0] sel);
    logic [CNT_W-1:0] n;
    case (sel)
      WSEL_8:  n = CNT_W'(8);
      WSEL_32: n = CNT_W'(32);
      default: n = CNT_W'(16);
    endcase
    return n;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_byte_at(input logic [PRES_W-1:0] p,
                                               input logic [TEMP_W-1:0] t,
                                               input logic [15:0] crc,
                                               input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = p[7:0];
      3'd1:    b = p[15:8];
      3'd2:    b = p[23:16];
      3'd3:    b = PAD_BYTE;
      3'd4:    b = t[7:0];
      3'd5:    b = t[15:8];
      3'd6:    b = crc[7:0];
      default: b = crc[15:8];
    endcase
    return b;
  endfunction

endpackage

/* sv/racfb_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and frame byte items.
// Depends on racfb_pkg for field widths.
interface racfb_in_if import racfb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     sample_present;
  logic                     fresh_sample;
  logic [PRES_W-1:0]        pressure;
  logic signed [TEMP_W-1:0] temperature;
  logic                     temperature_ok;

  modport source (output valid, sample_present, fresh_sample, pressure, temperature,
                  temperature_ok, input ready);
  modport sink   (input valid, sample_present, fresh_sample, pressure, temperature,
                  temperature_ok, output ready);
endinterface

interface racfb_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [2:0] byte_index;
  logic       last_byte;

  modport source (output valid, frame_byte, byte_index, last_byte, input ready);
  modport sink   (input valid, frame_byte, byte_index, last_byte, output ready);
endinterface

/* sv/racfb_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module racfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rolling_average_crc_frame_builder.sv */
`timescale 1ns / 1ps
// Rolling average pressure/temperature frame builder with CRC-16/MODBUS.
// Depends on racfb_pkg, racfb_ifs, racfb_ram and the assertion macro header.
//
// Usage:
//   in_ch carries one sampling period per item (valid/ready). An item with
//   sample_present low is dropped in its accept cycle and nothing is emitted.
//   A present item becomes eight out_ch items, bytes 0..7 of the frame, with
//   last_byte on the CRC high byte. cfg_we/cfg_index/cfg_wdata write the
//   averaging enable (index 0) and window select (index 1) while idle.
//   Timing: one item at a time; in_ch.ready is high only when idle. Without
//   averaging, 6 CRC byte steps run before the first byte shows.
//   With averaging over n entries, the history is read newest first and summed
//   through the registered RAM read port, then one shared restoring divider
//   divides pressure and then temperature by n before the CRC steps. Each
//   byte is held until taken, so a present item occupies the block until all
//   eight bytes are taken.
//   Reset clears the write pointer, fill count, registers and sequencer; the
//   history RAM is not cleared and holds nothing meaningful until written.
//   A stalled receiver holds the current byte; nothing is lost or repeated.
`include "rolling_average_crc_frame_builder_defines.svh"

module rolling_average_crc_frame_builder import racfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  racfb_in_if.sink              in_ch,
  racfb_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  racfb_state_t state_r, state_nxt;

  logic                     avg_en_r;
  logic [1:0]               win_sel_r;
  logic [ADDR_W-1:0]        wp_r, wp_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [ADDR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic                     acc_vld_r, acc_vld_nxt;
  logic [DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic [2:0]               cnt_r, cnt_nxt;

  logic [PRES_W-1:0]        p_r, p_nxt;
  logic [TEMP_W-1:0]        t_r, t_nxt;
  logic [15:0]              crc_r, crc_nxt;
  logic [PSUM_W-1:0]        psum_r, psum_nxt;
  logic signed [TSUM_W-1:0] tsum_r, tsum_nxt;
  logic [PSUM_W-1:0]        dq_r, dq_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;

  logic                     accept_present;
  logic                     hist_we;
  logic [TEMP_W-1:0]        t_in;
  logic [HIST_W-1:0]        rd_data;
  logic [ADDR_W-1:0]        wp_inc;
  logic [ADDR_W-1:0]        wp_after;
  logic [CNT_W-1:0]         fill_after;
  logic [CNT_W-1:0]         win_n;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic [TSUM_W-1:0]        tmag;
  logic [TEMP_W-1:0]        tq;
  logic [7:0]               cur_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_en_r  <= 1'b0;
      win_sel_r <= WSEL_16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AVG_EN:  avg_en_r  <= cfg_wdata[0];
        CFG_WIN_SEL: win_sel_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign accept_present = in_ch.valid && in_ch.ready && in_ch.sample_present;
  assign hist_we        = accept_present && in_ch.fresh_sample;
  assign t_in           = in_ch.temperature_ok ? in_ch.temperature : '0;

  assign wp_inc     = (wp_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign wp_after   = in_ch.fresh_sample ? wp_inc : wp_r;
  assign fill_after = (in_ch.fresh_sample && fill_r != CNT_W'(HISTORY_DEPTH))
                      ? fill_r + 1'b1 : fill_r;
  assign win_n      = window_size(win_sel_r);

  racfb_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_r),
    .wdata ({in_ch.pressure, t_in}),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  // Shared restoring divider step: one quotient bit per cycle
  assign trial    = {rem_r, dq_r[PSUM_W-1]};
  assign trial_ge = trial >= {1'b0, n_r};
  assign tmag     = tsum_r[TSUM_W-1] ? TSUM_W'(-tsum_r) : TSUM_W'(tsum_r);
  assign tq       = tsum_r[TSUM_W-1] ? TEMP_W'(-{dq_r[TEMP_W-2:0], trial_ge})
                                     : {dq_r[TEMP_W-2:0], trial_ge};

  assign cur_byte = frame_byte_at(p_r, t_r, crc_r, cnt_r);

  assign out_ch.valid      = (state_r == ST_OUT);
  assign out_ch.frame_byte = cur_byte;
  assign out_ch.byte_index = cnt_r;
  assign out_ch.last_byte  = (cnt_r == FRAME_LAST_IDX);

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    rd_ptr_nxt  = rd_ptr_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    acc_vld_nxt = 1'b0;
    div_cnt_nxt = div_cnt_r;
    cnt_nxt     = cnt_r;
    p_nxt       = p_r;
    t_nxt       = t_r;
    crc_nxt     = crc_r;
    psum_nxt    = psum_r;
    tsum_nxt    = tsum_r;
    dq_nxt      = {dq_r[PSUM_W-2:0], trial_ge};
    rem_nxt     = trial_ge ? CNT_W'(trial - {1'b0, n_r}) : trial[CNT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept_present) begin
          p_nxt    = in_ch.pressure;
          t_nxt    = t_in;
          wp_nxt   = wp_after;
          fill_nxt = fill_after;
          if (avg_en_r) begin
            // Clamp the window to the fill count, but read at least one entry
            if (win_n > fill_after) begin
              n_nxt = fill_after;
            end else begin
              n_nxt = win_n;
            end
            if (n_nxt == '0) begin
              n_nxt = CNT_W'(1);
            end
            rd_ptr_nxt = (wp_after == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : wp_after - 1'b1;
            k_nxt      = '0;
            psum_nxt   = '0;
            tsum_nxt   = '0;
            state_nxt  = ST_SUM;
          end else begin
            crc_nxt   = CRC_INIT;
            cnt_nxt   = '0;
            state_nxt = ST_CRC;
          end
        end
      end

      ST_SUM: begin
        // Issue one read per cycle, newest first; accumulate in the next cycle
        if (k_r != n_r) begin
          rd_ptr_nxt  = (rd_ptr_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : rd_ptr_r - 1'b1;
          k_nxt       = k_r + 1'b1;
          acc_vld_nxt = 1'b1;
        end
        if (acc_vld_r) begin
          psum_nxt = psum_r + PSUM_W'(rd_data[HIST_W-1:TEMP_W]);
          tsum_nxt = tsum_r + {{ADDR_W{rd_data[TEMP_W-1]}}, rd_data[TEMP_W-1:0]};
        end
        if (k_r == n_r && acc_vld_r) begin
          dq_nxt      = psum_nxt;
          rem_nxt     = '0;
          div_cnt_nxt = DIV_CNT_W'(PSUM_W - 1);
          state_nxt   = ST_DIV_P;
        end
      end

      ST_DIV_P: begin
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          p_nxt       = dq_nxt[PRES_W-1:0];
          dq_nxt      = PSUM_W'(tmag);
          rem_nxt     = '0;
          div_cnt_nxt = DIV_CNT_W'(PSUM_W - 1);
          state_nxt   = ST_DIV_T;
        end
      end

      ST_DIV_T: begin
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          // Truncate toward zero: divide the magnitude, then restore the sign
          t_nxt     = tq;
          crc_nxt   = CRC_INIT;
          cnt_nxt   = '0;
          state_nxt = ST_CRC;
        end
      end

      ST_CRC: begin
        crc_nxt = crc16_byte(crc_r, cur_byte);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CRC_LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ch.ready) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == FRAME_LAST_IDX) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      fill_r    <= '0;
      rd_ptr_r  <= '0;
      n_r       <= CNT_W'(1);
      k_r       <= '0;
      acc_vld_r <= 1'b0;
      div_cnt_r <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      acc_vld_r <= acc_vld_nxt;
      div_cnt_r <= div_cnt_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    t_r    <= t_nxt;
    crc_r  <= crc_nxt;
    psum_r <= psum_nxt;
    tsum_r <= tsum_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
  end

  `RACFB_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
  `RACFB_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(HISTORY_DEPTH))
  `RACFB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept_present, !in_ch.ready)
  `RACFB_ASSERT_IMPL(a_window_range, clk, rst_n, state_r == ST_SUM,
                     n_r != '0 && n_r <= CNT_W'(HISTORY_DEPTH) && k_r <= n_r)

endmodule

/* verif/rolling_average_crc_frame_builder_test.sv */
`timescale 1ns / 1ps
// Self-checking regression for the rolling average CRC frame builder: directed and random
// sample items over several register settings, each frame predicted and checked per byte.
// Depends on racfb_pkg, racfb_ifs and the rolling_average_crc_frame_builder RTL.
module rolling_average_crc_frame_builder_test;
  import racfb_pkg::*;

  localparam int                 CYCLE_LIMIT = 300000;
  localparam logic [1:0]         WSEL_16_ALT = 2'd3;
  localparam logic [PRES_W-1:0]  PRES_MAX    = 24'hFFFFFF;
  localparam logic [TEMP_W-1:0]  TEMP_MIN    = 16'h8000;
  localparam logic [TEMP_W-1:0]  TEMP_MAX    = 16'h7FFF;
  localparam int                 HOLD_AFTER  = 400;
  localparam int                 HOLD_CYCLES = 400;

  typedef struct packed {
    logic                     present;
    logic                     fresh;
    logic [PRES_W-1:0]        pressure;
    logic signed [TEMP_W-1:0] temperature;
    logic                     temp_ok;
  } sample_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] idx;
    logic       last;
  } frame_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  racfb_in_if  in_ch ();
  racfb_out_if out_ch ();

  rolling_average_crc_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the block state and registers
  logic [PRES_W-1:0]        pres_hist [HISTORY_DEPTH];
  logic signed [TEMP_W-1:0] temp_hist [HISTORY_DEPTH];
  int                       wr_slot;
  int                       hist_fill;
  logic                     avg_on;
  logic [1:0]               win_code;

  frame_byte_t frame_bytes_due [$];
  sample_t     pending_samples [$];
  sample_t     drv_cur;

  int queued_cnt, accepted_cnt, bytes_seen, frames_seen, mismatches, cfg_writes, cycle_cnt;
  int burst_left, gap_left;
  int rx_mode, rx_stretch, long_hold;
  bit hold_done, gen_filled;

  function automatic int unsigned window_len(input logic [1:0] code);
    case (code)
      WSEL_8:  return 8;
      WSEL_32: return 32;
      default: return 16;
    endcase
  endfunction

  task automatic build_expected_frame(input sample_t s);
    logic [PRES_W-1:0]        p;
    logic signed [TEMP_W-1:0] t;
    logic [7:0]               fb [8];
    logic [15:0]              crc;
    int unsigned              psum;
    int unsigned              n;
    int                       tsum;
    int                       slot;
    if (!s.present) return;
    p = s.pressure;
    t = s.temp_ok ? s.temperature : '0;
    if (s.fresh) begin
      pres_hist[wr_slot] = p;
      temp_hist[wr_slot] = t;
      wr_slot = (wr_slot + 1) % HISTORY_DEPTH;
      if (hist_fill < HISTORY_DEPTH) hist_fill++;
    end
    if (avg_on) begin
      n = window_len(win_code);
      if (n > hist_fill) n = hist_fill;
      if (n == 0) n = 1;
      psum = 0;
      tsum = 0;
      for (int k = 0; k < n; k++) begin
        slot = (wr_slot + HISTORY_DEPTH - 1 - k) % HISTORY_DEPTH;
        psum += pres_hist[slot];
        tsum += temp_hist[slot];
      end
      p = PRES_W'(psum / n);
      // signed division truncates toward zero
      t = TEMP_W'(tsum / int'(n));
    end
    fb[0] = p[7:0];
    fb[1] = p[15:8];
    fb[2] = p[23:16];
    fb[3] = PAD_BYTE;
    fb[4] = t[7:0];
    fb[5] = t[15:8];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc[7:0] = crc[7:0] ^ fb[i];
      repeat (8) crc = crc[0] ? ({1'b0, crc[15:1]} ^ CRC_POLY) : {1'b0, crc[15:1]};
    end
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      frame_bytes_due.push_back('{data: fb[i], idx: 3'(i), last: (3'(i) == FRAME_LAST_IDX)});
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < 40)
      $display("MISMATCH at out byte %0d, %s: got %0h, want %0h", bytes_seen, field, got, want);
    mismatches++;
  endtask

  function automatic sample_t mk_sample(input bit present, input bit fresh,
                                        input logic [PRES_W-1:0] p,
                                        input logic [TEMP_W-1:0] t, input bit ok);
    sample_t s;
    s.present     = present;
    s.fresh       = fresh;
    s.pressure    = p;
    s.temperature = t;
    s.temp_ok     = ok;
    return s;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.present = ($urandom_range(0, 7) != 0);
    s.fresh   = ($urandom_range(0, 3) != 0);
    s.temp_ok = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0:       s.pressure = '0;
      1:       s.pressure = PRES_MAX;
      2:       s.pressure = PRES_MAX - PRES_W'($urandom_range(0, 255));
      default: s.pressure = PRES_W'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0:       s.temperature = TEMP_MIN;
      1:       s.temperature = TEMP_MAX;
      2:       s.temperature = TEMP_W'($urandom_range(0, 200) - 100);
      default: s.temperature = TEMP_W'($urandom());
    endcase
    return s;
  endfunction

  // Never average an empty history: force the first present item to be fresh.
  task automatic queue_sample(input sample_t s);
    if (avg_on && !gen_filled && s.present) s.fresh = 1'b1;
    if (s.present && s.fresh) gen_filled = 1'b1;
    pending_samples.push_back(s);
    queued_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AVG_EN) avg_on = val[0];
    else win_code = val;
    cfg_writes++;
  endtask

  task automatic set_config(input logic avg, input logic [1:0] win);
    write_reg(CFG_AVG_EN, CFG_DATA_W'(avg));
    write_reg(CFG_WIN_SEL, win);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || frame_bytes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Sender: bursts of items from the pending queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        build_expected_frame(drv_cur);
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          drv_cur = pending_samples.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.sample_present <= drv_cur.present;
          in_ch.fresh_sample   <= drv_cur.fresh;
          in_ch.pressure       <= drv_cur.pressure;
          in_ch.temperature    <= drv_cur.temperature;
          in_ch.temperature_ok <= drv_cur.temp_ok;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stretches of always-ready, half-ready and mostly-stalled, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode    = 0;
      rx_stretch = 0;
      long_hold  = 0;
    end else if (long_hold > 0) begin
      out_ch.ready <= 1'b0;
      long_hold--;
    end else if (!hold_done && bytes_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      long_hold = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode    = $urandom_range(0, 2);
        rx_stretch = $urandom_range(10, 60);
      end else begin
        rx_stretch--;
      end
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each accepted byte with the oldest prediction
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch("unexpected byte", out_ch.frame_byte, 0);
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_ch.frame_byte !== want.data)
          report_mismatch("frame_byte", out_ch.frame_byte, want.data);
        if (out_ch.byte_index !== want.idx)
          report_mismatch("byte_index", out_ch.byte_index, want.idx);
        if (out_ch.last_byte !== want.last)
          report_mismatch("last_byte", out_ch.last_byte, want.last);
      end
      if (out_ch.last_byte === 1'b1) frames_seen++;
      bytes_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_cnt,
               frame_bytes_due.size());
      $display("rolling_average_crc_frame_builder regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.sample_present = 1'b0;
    in_ch.fresh_sample   = 1'b0;
    in_ch.pressure       = '0;
    in_ch.temperature    = '0;
    in_ch.temperature_ok = 1'b0;
    out_ch.ready         = 1'b0;
    wr_slot   = 0;
    hist_fill = 0;
    avg_on    = 1'b0;
    win_code  = WSEL_16;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: no averaging, own values framed
    queue_sample(mk_sample(1, 1, '0, '0, 1));
    queue_sample(mk_sample(1, 1, PRES_MAX, TEMP_MAX, 1));
    // absent sample flagged fresh: no frame, no history update
    queue_sample(mk_sample(0, 1, 24'h123456, 16'hFFFB, 1));
    // present but stale: own values framed, history untouched
    queue_sample(mk_sample(1, 0, 24'hABCDEF, TEMP_MIN, 1));
    // failed temperature read: zero framed and stored
    queue_sample(mk_sample(1, 1, PRES_MAX, TEMP_MIN, 0));
    wait_drained();

    // Window wider than the fill count: clamp to what is stored
    set_config(1'b1, WSEL_32);
    queue_sample(mk_sample(1, 0, 24'h000055, 16'h1234, 1));
    queue_sample(mk_sample(1, 1, PRES_MAX, TEMP_MIN, 1));
    queue_sample(mk_sample(1, 1, PRES_MAX, TEMP_MIN, 1));
    queue_sample(mk_sample(0, 1, 24'h0F0F0F, 16'h0F0F, 1));
    queue_sample(mk_sample(1, 1, 24'h000001, 16'hFFFF, 1));
    queue_sample(mk_sample(1, 0, 24'h00AA00, 16'h0007, 0));
    wait_drained();

    set_config(1'b1, WSEL_8);
    for (int i = 0; i < 6; i++)
      queue_sample(mk_sample(1, 1, PRES_MAX, (i % 2) ? TEMP_MAX : TEMP_MIN, 1));
    queue_sample(mk_sample(1, 1, 24'h000003, 16'hFFFD, 1));
    wait_drained();

    set_config(1'b1, WSEL_16_ALT);
    queue_sample(mk_sample(1, 1, 24'h7FFFFF, 16'hFFFE, 1));
    queue_sample(mk_sample(1, 0, 24'h800000, 16'h8001, 1));
    queue_sample(mk_sample(1, 1, '0, TEMP_MAX, 0));
    wait_drained();

    // Random phases across the register settings
    begin
      logic       avg_list [7];
      logic [1:0] win_list [7];
      avg_list = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      win_list = '{WSEL_16, WSEL_8, WSEL_32, WSEL_16, WSEL_8, WSEL_16_ALT, WSEL_32};
      for (int ph = 0; ph < 7; ph++) begin
        set_config(avg_list[ph], win_list[ph]);
        for (int i = 0; i < 28; i++) queue_sample(rand_sample());
        wait_drained();
      end
    end

    $display("Ran %0d sample items into %0d frames (%0d bytes) over %0d register writes.",
             accepted_cnt, frames_seen, bytes_seen, cfg_writes);
    $display("History reached %0d entries; windows of 8, 16 and 32 with clamping, one long stall.",
             hist_fill);
    if (mismatches == 0) begin
      $display("rolling_average_crc_frame_builder regression: pass");
    end else begin
      $display("rolling_average_crc_frame_builder regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/racfb_pkg.sv
sv/racfb_ifs.sv
sv/racfb_ram.sv
sv/rolling_average_crc_frame_builder.sv
verif/rolling_average_crc_frame_builder_test.sv
